FILE: design/cmfs_pkg.sv
// Package for the CAN multi-frame segmenter: register indexes, reset values,
// result layout and stream packing offsets. No dependencies.
package cmfs_pkg;

    // Default payload bytes per CAN frame (one byte of the eight is the tail).
    localparam int BYTES_PER_FRAME_DEF = 7;

    localparam int ID_W       = 29;
    localparam int MAX_W      = 8;
    localparam int DATA_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_DATA_W = 29;
    localparam int CFG_IDX_W  = 1;
    localparam int CTR_W      = 5;

    localparam logic [ID_W-1:0]  ID_RESET  = ID_W'(32'h0016_E416);
    localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(224);

    // Master tdata layout, lowest bits first, zero filled to whole bytes.
    localparam int TD_DATA_LSB = 0;
    localparam int TD_LEN_LSB  = TD_DATA_LSB + DATA_W;
    localparam int TD_ID_LSB   = TD_LEN_LSB + LEN_W;
    localparam int TD_USED_W   = TD_ID_LSB + ID_W;
    localparam int M_TDATA_W   = ((TD_USED_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_EXT_ID = 1'b0,
        REG_MAX_BYTES    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [DATA_W-1:0] frame_data;
        logic [LEN_W-1:0]  frame_length;
        logic [ID_W-1:0]   frame_id;
        logic              length_error;
    } result_t;

endpackage

FILE: design/can_multi_frame_segmenter.sv
// Top level of the CAN multi-frame segmenter: byte packing, tail byte
// generation, length check and a two-entry result stage. Uses cmfs_pkg.

// The block takes one payload byte per cycle on the slave stream (tlast marks
// the final byte of a transfer) and emits one CAN frame on the master stream
// each time BYTES_PER_FRAME bytes have gathered or the transfer ends. Every
// byte is handled in the cycle it is accepted; its frame, if any, is
// registered in the result stage. The result stage holds two frames, so input
// keeps flowing while one frame waits; s_tready drops only when both entries
// are full. A transfer longer than max_bytes yields one error transaction
// (tuser set, length and data zero) and its remaining bytes are swallowed.
// Configuration writes are always ready and belong between transfers.
module can_multi_frame_segmenter
    import cmfs_pkg::*;
#(
    parameter int BYTES_PER_FRAME = BYTES_PER_FRAME_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Slave stream. tdata: data_byte[7:0]. tlast: last_byte.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    // Master stream. tdata: frame_data[63:0], frame_length[67:64],
    // frame_id[96:68], zero fill[103:97]. tuser: length_error[0].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]            m_tuser,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HC_W = $clog2(BYTES_PER_FRAME + 1);
    localparam int CNT_W = MAX_W + 1;

    // Configuration registers.
    logic [ID_W-1:0]  frame_ext_id_reg;
    logic [MAX_W-1:0] max_bytes_reg;

    // Transfer state.
    logic [7:0]       held_reg [BYTES_PER_FRAME];
    logic [HC_W-1:0]  held_count_reg, held_count_next;
    logic [CTR_W-1:0] frame_counter_reg, frame_counter_next;
    logic             toggle_reg, toggle_next;
    logic [MAX_W-1:0] bytes_in_transfer_reg, bytes_in_transfer_next;
    logic             aborting_reg, aborting_next;

    // Result stage: output register and skid entry behind it.
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic             accept;
    logic             pop;
    logic             push;
    logic [CNT_W-1:0] count;
    logic [HC_W-1:0]  hc_new;
    logic             frame_done;
    logic             over_limit;
    logic [7:0]       tail;
    logic [DATA_W-1:0] frame_data;
    result_t          res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;

    assign count      = CNT_W'(bytes_in_transfer_reg) + CNT_W'(1);
    assign over_limit = count > CNT_W'(max_bytes_reg);
    assign hc_new     = held_count_reg + HC_W'(1);
    assign frame_done = (hc_new == HC_W'(BYTES_PER_FRAME)) || s_tlast;

    // Tail: start, end, toggle, then the frame counter in the low bits.
    // Start is set when every byte so far sits in this frame.
    assign tail = {(count == CNT_W'(hc_new)), s_tlast, toggle_reg, frame_counter_reg};

    always_comb
    begin
        frame_data = '0;
        for (int p = 0; p < BYTES_PER_FRAME; p++)
        begin
            if (HC_W'(p) < held_count_reg)
                frame_data[8*p +: 8] = held_reg[p];
            else if (HC_W'(p) == held_count_reg)
                frame_data[8*p +: 8] = s_tdata;
        end
        for (int p = 0; p <= BYTES_PER_FRAME; p++)
        begin
            if (HC_W'(p) == hc_new)
                frame_data[8*p +: 8] = tail;
        end
    end

    always_comb
    begin
        res.frame_id = frame_ext_id_reg;
        if (over_limit)
        begin
            res.frame_data   = '0;
            res.frame_length = '0;
            res.length_error = 1'b1;
        end
        else
        begin
            res.frame_data   = frame_data;
            res.frame_length = LEN_W'(hc_new) + LEN_W'(1);
            res.length_error = 1'b0;
        end
    end

    // Transfer state update for one accepted byte.
    always_comb
    begin
        held_count_next        = held_count_reg;
        frame_counter_next     = frame_counter_reg;
        toggle_next            = toggle_reg;
        bytes_in_transfer_next = bytes_in_transfer_reg;
        aborting_next          = aborting_reg;
        push                   = 1'b0;
        if (accept)
        begin
            priority if (aborting_reg)
            begin
                if (s_tlast)
                begin
                    held_count_next        = '0;
                    frame_counter_next     = '0;
                    toggle_next            = 1'b0;
                    bytes_in_transfer_next = '0;
                    aborting_next          = 1'b0;
                end
            end
            else if (over_limit)
            begin
                push            = 1'b1;
                held_count_next = '0;
                if (s_tlast)
                begin
                    frame_counter_next     = '0;
                    toggle_next            = 1'b0;
                    bytes_in_transfer_next = '0;
                end
                else
                begin
                    aborting_next = 1'b1;
                end
            end
            else
            begin
                bytes_in_transfer_next = count[MAX_W-1:0];
                held_count_next        = hc_new;
                if (frame_done)
                begin
                    push            = 1'b1;
                    held_count_next = '0;
                    if (s_tlast)
                    begin
                        frame_counter_next     = '0;
                        toggle_next            = 1'b0;
                        bytes_in_transfer_next = '0;
                    end
                    else
                    begin
                        frame_counter_next = frame_counter_reg + CTR_W'(1);
                        toggle_next        = !toggle_reg;
                    end
                end
            end
        end
    end

    // Two-entry result stage; the skid entry fills only while the
    // output register is stalled.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ext_id_reg      <= ID_RESET;
            max_bytes_reg         <= MAX_RESET;
            held_count_reg        <= '0;
            frame_counter_reg     <= '0;
            toggle_reg            <= 1'b0;
            bytes_in_transfer_reg <= '0;
            aborting_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            skid_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FRAME_EXT_ID: frame_ext_id_reg <= cfg_data[ID_W-1:0];
                    REG_MAX_BYTES:    max_bytes_reg    <= cfg_data[MAX_W-1:0];
                    default:          ;
                endcase
            end
            held_count_reg        <= held_count_next;
            frame_counter_reg     <= frame_counter_next;
            toggle_reg            <= toggle_next;
            bytes_in_transfer_reg <= bytes_in_transfer_next;
            aborting_reg          <= aborting_next;
            out_valid_reg         <= out_valid_next;
            skid_valid_reg        <= skid_valid_next;
        end
    end

    // Payload storage, no reset needed.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (accept && !aborting_reg && !over_limit)
        begin
            for (int i = 0; i < BYTES_PER_FRAME; i++)
            begin
                if (HC_W'(i) == held_count_reg)
                    held_reg[i] <= s_tdata;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.length_error;
    assign m_tdata  = M_TDATA_W'({out_reg.frame_id, out_reg.frame_length, out_reg.frame_data});

endmodule

FILE: design/cmfs_checker.sv
// Port-level checker for the CAN multi-frame segmenter, bound to the top
// level. Uses cmfs_pkg for the stream layout.
module cmfs_checker
    import cmfs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // A stalled master transaction holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("master payload changed while stalled");

    // An error transaction carries no frame bytes and a zero length.
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[TD_ID_LSB-1:0] == '0)
        else $error("error transaction carries frame content");

    // A frame holds at least one payload byte plus the tail.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |->
            m_tdata[TD_ID_LSB-1:TD_LEN_LSB] >= LEN_W'(2) &&
            m_tdata[TD_ID_LSB-1:TD_LEN_LSB] <= LEN_W'(8))
        else $error("frame length out of range");

    // The input stalls only when a frame is waiting on the output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending output");

endmodule

bind can_multi_frame_segmenter cmfs_checker u_cmfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
